/* hw/rtl/ktss_pkg.sv */
// Shared types and constants for the keyed top-k score set.
package ktss_pkg;

  localparam int MAX_CAPACITY_DEF = 16;
  localparam int ID_W             = 32;
  localparam int SCORE_W          = 32;
  localparam int SLOT_W           = 4;
  localparam int CFG_W            = 5;
  localparam int CNT_OUT_W        = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [ID_W-1:0]    seg_id;
    logic [SCORE_W-1:0] score_key;
    logic [SLOT_W-1:0]  slot_index;
  } ktss_in_t;

  typedef struct packed {
    logic                 accepted;
    logic                 evicted_valid;
    logic [ID_W-1:0]      evicted_id;
    logic [SCORE_W-1:0]   threshold;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 read_valid;
    logic [ID_W-1:0]      read_id;
    logic [SCORE_W-1:0]   read_score;
  } ktss_out_t;

  // One stored entry as it moves between neighboring cells
  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
  } ktss_link_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_REMOVE,
    OP_INSERT,
    OP_EVICT
  } ktss_op_t;

  typedef struct packed {
    ktss_op_t           op;
    logic [ID_W-1:0]    key_id;
    logic [SCORE_W-1:0] key_score;
  } ktss_cmd_t;

  typedef struct packed {
    logic hit;
    logic ins;
    logic tail;
  } ktss_flag_t;

  typedef struct packed {
    logic               hit_any;
    logic [ID_W-1:0]    tail_id;
    logic [SCORE_W-1:0] pre_score;
    logic               rd_valid;
    logic [ID_W-1:0]    rd_id;
    logic [SCORE_W-1:0] rd_score;
  } ktss_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_REMOVE,
    ST_INSERT,
    ST_EVICT
  } ktss_state_t;

endpackage

/* hw/rtl/ktss_cell.sv */
// One cell of the score-sorted entry chain.
module ktss_cell #(
  parameter int AGE_W = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ktss_pkg::ktss_cmd_t          cmd,
  input  logic                         ref_hit,
  input  logic [ktss_pkg::SCORE_W-1:0] ref_score,
  input  logic [AGE_W-1:0]             ref_age,
  input  logic [AGE_W-1:0]             new_age,
  input  ktss_pkg::ktss_link_t         left_link,
  input  logic [AGE_W-1:0]             left_age,
  input  ktss_pkg::ktss_flag_t         left_flag,
  input  ktss_pkg::ktss_link_t         right_link,
  input  logic [AGE_W-1:0]             right_age,
  output ktss_pkg::ktss_link_t         link,
  output logic [AGE_W-1:0]             age,
  output ktss_pkg::ktss_flag_t         flag
);
  import ktss_pkg::*;

  logic               valid_r;
  logic [ID_W-1:0]    id_r;
  logic [SCORE_W-1:0] score_r;
  logic [AGE_W-1:0]   age_r;
  ktss_link_t         ent_nxt;
  logic [AGE_W-1:0]   age_nxt;
  logic [AGE_W-1:0]   age_adj;
  logic [AGE_W-1:0]   right_age_adj;
  logic               after_ref;

  assign link.valid = valid_r;
  assign link.id    = id_r;
  assign link.score = score_r;
  assign age        = age_r;

  assign flag.hit  = valid_r && (id_r == cmd.key_id);
  assign flag.ins  = !valid_r || (score_r <= cmd.key_score);
  assign flag.tail = valid_r && !right_link.valid;

  // Close the rank gap left by the removed entry
  assign age_adj       = age_r - AGE_W'(age_r > ref_age);
  assign right_age_adj = right_age - AGE_W'(right_age > ref_age);

  // Entry sits at or behind the removed one in (score desc, age desc) order
  assign after_ref = !valid_r || (score_r < ref_score) ||
                     ((score_r == ref_score) && (age_r <= ref_age));

  always_comb begin
    ent_nxt = link;
    age_nxt = age_r;
    unique case (cmd.op)
      OP_HOLD: begin
      end
      OP_REMOVE: begin
        if (ref_hit) begin
          if (after_ref) begin
            ent_nxt = right_link;
            age_nxt = right_age_adj;
          end else begin
            age_nxt = age_adj;
          end
        end
      end
      OP_INSERT: begin
        if (left_flag.ins) begin
          ent_nxt = left_link;
          age_nxt = left_age;
        end else if (flag.ins) begin
          ent_nxt.valid = 1'b1;
          ent_nxt.id    = cmd.key_id;
          ent_nxt.score = cmd.key_score;
          age_nxt       = new_age;
        end
      end
      OP_EVICT: begin
        if (flag.tail) begin
          ent_nxt.valid = 1'b0;
        end else begin
          age_nxt = age_adj;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      age_r   <= '0;
    end else begin
      valid_r <= ent_nxt.valid;
      age_r   <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r    <= ent_nxt.id;
    score_r <= ent_nxt.score;
  end

endmodule

/* hw/rtl/ktss_chain.sv */
// Row of entry cells with match, tail and read selection.
module ktss_chain #(
  parameter int MAX_CAPACITY = ktss_pkg::MAX_CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ktss_pkg::ktss_cmd_t                cmd,
  input  logic [$clog2(MAX_CAPACITY+1)-1:0]  new_age,
  input  logic [ktss_pkg::SLOT_W-1:0]        slot,
  output ktss_pkg::ktss_stat_t               stat
);
  import ktss_pkg::*;

  localparam int NCELL = MAX_CAPACITY + 1;
  localparam int AGE_W = $clog2(MAX_CAPACITY + 1);
  localparam int SW    = (AGE_W > SLOT_W) ? AGE_W : SLOT_W;

  ktss_link_t         links [NCELL];
  logic [AGE_W-1:0]   ages  [NCELL];
  ktss_flag_t         flags [NCELL];
  logic [NCELL-1:0]   hit_vec;
  logic [NCELL-1:0]   tail_vec;
  logic [NCELL-1:0]   pre_vec;
  logic [NCELL-1:0]   ins_vec;
  logic [NCELL-1:0]   rd_vec;
  logic [SCORE_W-1:0] hit_score;
  logic [AGE_W-1:0]   hit_age;
  logic [AGE_W-1:0]   tail_age;
  logic [AGE_W-1:0]   ref_age;
  logic               ref_hit;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ktss_link_t       l_link;
    logic [AGE_W-1:0] l_age;
    ktss_flag_t       l_flag;
    ktss_link_t       r_link;
    logic [AGE_W-1:0] r_age;

    if (i == 0) begin : g_head
      assign l_link = '0;
      assign l_age  = '0;
      assign l_flag = '0;
    end else begin : g_left
      assign l_link = links[i-1];
      assign l_age  = ages[i-1];
      assign l_flag = flags[i-1];
    end

    if (i == NCELL - 1) begin : g_last
      assign r_link     = '0;
      assign r_age      = '0;
      assign pre_vec[i] = 1'b0;
    end else begin : g_right
      assign r_link     = links[i+1];
      assign r_age      = ages[i+1];
      assign pre_vec[i] = links[i].valid && flags[i+1].tail;
    end

    ktss_cell #(
      .AGE_W (AGE_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .ref_hit    (ref_hit),
      .ref_score  (hit_score),
      .ref_age    (ref_age),
      .new_age    (new_age),
      .left_link  (l_link),
      .left_age   (l_age),
      .left_flag  (l_flag),
      .right_link (r_link),
      .right_age  (r_age),
      .link       (links[i]),
      .age        (ages[i]),
      .flag       (flags[i])
    );

    assign hit_vec[i]  = flags[i].hit;
    assign tail_vec[i] = flags[i].tail;
    assign ins_vec[i]  = flags[i].ins;
    assign rd_vec[i]   = links[i].valid && (SW'(ages[i]) == SW'(slot));
  end

  assign ref_hit = |hit_vec;
  assign ref_age = (cmd.op == OP_EVICT) ? tail_age : hit_age;

  // One-hot selects: at most one cell raises each vector
  always_comb begin
    hit_score       = '0;
    hit_age         = '0;
    tail_age        = '0;
    stat            = '0;
    for (int i = 0; i < NCELL; i++) begin
      hit_score      |= {SCORE_W{hit_vec[i]}} & links[i].score;
      hit_age        |= {AGE_W{hit_vec[i]}} & ages[i];
      tail_age       |= {AGE_W{tail_vec[i]}} & ages[i];
      stat.tail_id   |= {ID_W{tail_vec[i]}} & links[i].id;
      stat.pre_score |= {SCORE_W{pre_vec[i]}} & links[i].score;
      stat.rd_id     |= {ID_W{rd_vec[i]}} & links[i].id;
      stat.rd_score  |= {SCORE_W{rd_vec[i]}} & links[i].score;
    end
    stat.hit_any  = ref_hit;
    stat.rd_valid = |rd_vec;
  end

`ifndef SYNTHESIS
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one cell holds the offered id");

  a_tail_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tail_vec))
    else $error("valid cells are not packed at the head of the chain");

  a_ins_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ins_vec ^ {ins_vec[NCELL-2:0], 1'b0}))
    else $error("chain is not sorted by score");
`endif

endmodule

/* hw/rtl/keyed_top_k_score_set_unit.sv */
// Top level of the keyed top-k score set: sequencer, registers and result port.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------
//   input    | start, busy            | in_data  (ktss_in_t)
//   result   | out_strobe             | out_data (ktss_out_t)
//   config   | cfg_we                 | cfg_wdata (set_capacity)
//
// A read passes through the read state; its result is registered and then strobed.
// An update makes remove, insert and evict passes through the cell chain, one pass
// per cycle; an update at or below the threshold is dropped in the remove state.
// Reset is synchronous; the chain is empty right after reset, with no clearing pass.
// Results are held for one cycle only; the receiver cannot stall.
module keyed_top_k_score_set_unit #(
  parameter int MAX_CAPACITY = ktss_pkg::MAX_CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  ktss_pkg::ktss_in_t         in_data,
  output logic                       busy,
  output logic                       out_strobe,
  output ktss_pkg::ktss_out_t        out_data,
  input  logic                       cfg_we,
  input  logic [ktss_pkg::CFG_W-1:0] cfg_wdata
);
  import ktss_pkg::*;

  localparam int AGE_W = $clog2(MAX_CAPACITY + 1);
  localparam int CNT_W = $clog2(MAX_CAPACITY + 2);
  localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  ktss_state_t        state_r, state_nxt;
  ktss_in_t           item_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SCORE_W-1:0] thresh_r, thresh_nxt;
  logic [CFG_W-1:0]   cap_r;
  ktss_out_t          out_r, out_nxt;
  logic               out_strobe_r, strobe_nxt;
  ktss_cmd_t          cmd;
  logic [AGE_W-1:0]   new_age;
  ktss_stat_t         stat;
  logic [CW-1:0]      cap_eff;
  logic               reject;
  logic               over;

  ktss_chain #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .new_age (new_age),
    .slot    (item_r.slot_index),
    .stat    (stat)
  );

  // Clamp capacity to 1..MAX_CAPACITY
  always_comb begin
    cap_eff = CW'(cap_r);
    if (cap_r == '0) begin
      cap_eff = CW'(1);
    end else if (cap_eff > CW'(MAX_CAPACITY)) begin
      cap_eff = CW'(MAX_CAPACITY);
    end
  end

  assign reject = (item_r.score_key <= thresh_r);
  assign over   = (CW'(count_r) > cap_eff);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_data.cmd == CMD_READ) ? ST_READ : ST_REMOVE;
        end
      end
      ST_READ:   state_nxt = ST_IDLE;
      ST_REMOVE: state_nxt = reject ? ST_IDLE : ST_INSERT;
      ST_INSERT: state_nxt = ST_EVICT;
      ST_EVICT:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = (state_r != ST_IDLE);
    cmd.op        = OP_HOLD;
    cmd.key_id    = item_r.seg_id;
    cmd.key_score = item_r.score_key;
    new_age       = AGE_W'(count_r);
    count_nxt     = count_r;
    thresh_nxt    = thresh_r;
    strobe_nxt    = 1'b0;
    out_nxt       = '0;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_READ: begin
        strobe_nxt         = 1'b1;
        out_nxt.read_valid = stat.rd_valid;
        out_nxt.read_id    = stat.rd_id;
        out_nxt.read_score = stat.rd_score;
      end
      ST_REMOVE: begin
        if (reject) begin
          strobe_nxt = 1'b1;
        end else begin
          cmd.op    = OP_REMOVE;
          count_nxt = count_r - CNT_W'(stat.hit_any);
        end
      end
      ST_INSERT: begin
        cmd.op    = OP_INSERT;
        count_nxt = count_r + CNT_W'(1);
      end
      ST_EVICT: begin
        strobe_nxt       = 1'b1;
        out_nxt.accepted = 1'b1;
        if (over) begin
          cmd.op                = OP_EVICT;
          count_nxt             = count_r - CNT_W'(1);
          thresh_nxt            = stat.pre_score;
          out_nxt.evicted_valid = 1'b1;
          out_nxt.evicted_id    = stat.tail_id;
        end
      end
    endcase
    out_nxt.threshold   = thresh_nxt;
    out_nxt.entry_count = CNT_OUT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      thresh_r     <= '0;
      cap_r        <= CAP_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      thresh_r     <= thresh_nxt;
      out_strobe_r <= strobe_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // Hold the item for the whole transfer
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (count_r <= CNT_W'(MAX_CAPACITY)))
    else $error("entry count above capacity between items");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (state_r == ST_IDLE))
    else $error("result strobed while an item is still in work");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ($past(state_r) == ST_READ || $past(state_r) == ST_REMOVE ||
                      $past(state_r) == ST_EVICT))
    else $error("result strobed from a pass that does not finish an item");

  a_thresh_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_EVICT) |=> $stable(thresh_r))
    else $error("threshold moved outside an eviction");
`endif

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the keyed top-k score set unit.
`timescale 1ns / 1ps

module testbench;
  import ktss_pkg::*;

  localparam int SLOT_DEPTH     = MAX_CAPACITY_DEF + 1;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int POOL_SIZE      = 20;
  localparam int N_PHASES       = 8;
  localparam int PHASE_ITEMS    = 112;
  localparam int DIR_ROWS       = 25;
  localparam logic [31:0] SCORE_STEP = 32'h0010_0000;

  typedef enum logic {ROW_XFER, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    ktss_in_t          item;
    logic              typed;
    ktss_out_t         want;
    logic [CFG_W-1:0]  cap;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  ktss_in_t           in_data;
  logic               busy;
  logic               out_strobe;
  ktss_out_t          out_data;
  logic               cfg_we;
  logic [CFG_W-1:0]   cfg_wdata;

  // Predictor state: slots packed oldest first
  logic [ID_W-1:0]    held_ids    [SLOT_DEPTH];
  logic [SCORE_W-1:0] held_scores [SLOT_DEPTH];
  int                 held_count;
  logic [SCORE_W-1:0] admit_thr;
  logic [CFG_W-1:0]   cap_setting;
  int                 written_upto;

  ktss_out_t          pending_results [$];
  int                 fail_count;
  int                 idle_cycles;
  logic [ID_W-1:0]    id_pool [POOL_SIZE];
  dir_row_t           dir_table [DIR_ROWS];
  logic [CFG_W-1:0]   phase_caps [N_PHASES];

  keyed_top_k_score_set_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_data    (in_data),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void drop_slot(input int pos);
    int i;
    for (i = pos; i + 1 < held_count; i++) begin
      held_ids[i]    = held_ids[i + 1];
      held_scores[i] = held_scores[i + 1];
    end
    held_count--;
    held_ids[held_count]    = '0;
    held_scores[held_count] = '0;
  endfunction

  function automatic ktss_out_t predict_score_set(input ktss_in_t item);
    ktss_out_t r;
    int i;
    int hit;
    int lo;
    int eff_cap;
    int slot;
    logic [SCORE_W-1:0] m;
    r = '0;
    slot = int'(item.slot_index);
    eff_cap = (cap_setting == 0) ? 1 :
              (int'(cap_setting) > MAX_CAPACITY_DEF) ? MAX_CAPACITY_DEF : int'(cap_setting);
    if (item.cmd == CMD_READ) begin
      if (slot < held_count) begin
        r.read_valid = 1'b1;
        r.read_id    = held_ids[slot];
        r.read_score = held_scores[slot];
      end
    end else if (item.score_key > admit_thr) begin
      r.accepted = 1'b1;
      hit = -1;
      for (i = 0; i < held_count; i++)
        if (hit < 0 && held_ids[i] == item.seg_id) hit = i;
      // a replaced entry counts as newly inserted
      if (hit >= 0) drop_slot(hit);
      if (held_count < SLOT_DEPTH) begin
        held_ids[held_count]    = item.seg_id;
        held_scores[held_count] = item.score_key;
        held_count++;
        if (held_count > written_upto) written_upto = held_count;
      end
      if (held_count > eff_cap) begin
        // strict compare picks the oldest among equal scores for eviction
        lo = 0;
        for (i = 1; i < held_count; i++)
          if (held_scores[i] < held_scores[lo]) lo = i;
        r.evicted_valid = 1'b1;
        r.evicted_id    = held_ids[lo];
        drop_slot(lo);
        if (held_count > 0) begin
          m = held_scores[0];
          for (i = 1; i < held_count; i++)
            if (held_scores[i] < m) m = held_scores[i];
          admit_thr = m;
        end
      end
    end
    r.threshold   = admit_thr;
    r.entry_count = CNT_OUT_W'(held_count);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_item(input ktss_in_t item, input int gap, input logic typed,
                           input ktss_out_t want);
    ktss_out_t predicted;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = predict_score_set(item);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cap_setting = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result checker: every strobed result pops the oldest expectation
  always @(posedge clk) begin
    ktss_out_t exp_res;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: %h", out_data);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("accepted",      32'(exp_res.accepted),      32'(out_data.accepted));
        check_field("evicted_valid", 32'(exp_res.evicted_valid), 32'(out_data.evicted_valid));
        check_field("evicted_id",    exp_res.evicted_id,         out_data.evicted_id);
        check_field("threshold",     exp_res.threshold,          out_data.threshold);
        check_field("entry_count",   32'(exp_res.entry_count),   32'(out_data.entry_count));
        check_field("read_valid",    32'(exp_res.read_valid),    32'(out_data.read_valid));
        check_field("read_id",       exp_res.read_id,            out_data.read_id);
        check_field("read_score",    exp_res.read_score,         out_data.read_score);
      end
    end
  end

  // Watchdog: count cycles without any transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_strobe === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    ktss_in_t item;
    int pick;
    int gap;
    int read_limit;
    logic [SCORE_W-1:0] headroom;

    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_data     <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= CAP_RESET;
    idle_cycles <= 0;
    fail_count  = 0;
    held_count  = 0;
    admit_thr   = '0;
    cap_setting = CAP_RESET;
    written_upto = 0;
    for (int i = 0; i < SLOT_DEPTH; i++) begin
      held_ids[i]    = '0;
      held_scores[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    phase_caps = '{5'd1, 5'd0, 5'd6, 5'd2, 5'd31, 5'd9, 5'd17, 5'd16};

    dir_table = '{
      // after reset: zero score sits at the threshold and is dropped
      '{ROW_XFER, '{CMD_UPDATE, 32'h1, 32'h0, 4'h0}, 1'b1,
        '{1'b0, 1'b0, 32'h0, 32'h0, 5'd0, 1'b0, 32'h0, 32'h0}, 5'd0},
      '{ROW_XFER, '{CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF}, 1'b1,
        '{1'b1, 1'b0, 32'h0, 32'h0, 5'd1, 1'b0, 32'h0, 32'h0}, 5'd0},
      '{ROW_XFER, '{CMD_READ, 32'h0, 32'h0, 4'h0}, 1'b1,
        '{1'b0, 1'b0, 32'h0, 32'h0, 5'd1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 5'd0},
      '{ROW_XFER, '{CMD_UPDATE, 32'h0, 32'h1, 4'h0}, 1'b1,
        '{1'b1, 1'b0, 32'h0, 32'h0, 5'd2, 1'b0, 32'h0, 32'h0}, 5'd0},
      // replace with a lower score
      '{ROW_XFER, '{CMD_UPDATE, 32'hFFFF_FFFF, 32'd2, 4'h0}, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_UPDATE, 32'd2, 32'd500000, 4'h0}, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_UPDATE, 32'd3, 32'd1000000, 4'h0}, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_UPDATE, 32'd0, 32'd2500000, 4'h0}, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_READ, 32'h0, 32'h0, 4'd3}, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_READ, 32'h0, 32'h0, 4'd0}, 1'b0, '0, 5'd0},
      // capacity below the current count
      '{ROW_CAP, '0, 1'b0, '0, 5'd3},
      '{ROW_XFER, '{CMD_UPDATE, 32'd4, 32'd700000, 4'h0}, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_UPDATE, 32'd3, 32'd1200000, 4'h0}, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_UPDATE, 32'd5, 32'd700000, 4'h0}, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_UPDATE, 32'd6, 32'd2500000, 4'h0}, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_UPDATE, 32'd7, 32'd1200001, 4'h0}, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_UPDATE, 32'd7, 32'd2500000, 4'h0}, 1'b0, '0, 5'd0},
      // newcomer lands below every held score and evicts itself
      '{ROW_XFER, '{CMD_UPDATE, 32'd8, 32'd1300000, 4'h0}, 1'b0, '0, 5'd0},
      // three-way tie: the oldest goes
      '{ROW_XFER, '{CMD_UPDATE, 32'd9, 32'd2600000, 4'h0}, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_READ, 32'h0, 32'h0, 4'd2}, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_READ, 32'h0, 32'h0, 4'd3}, 1'b0, '0, 5'd0},
      // zero capacity behaves as one
      '{ROW_CAP, '0, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_UPDATE, 32'd10, 32'd2600000, 4'h0}, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_UPDATE, 32'd9, 32'd3000000, 4'h0}, 1'b0, '0, 5'd0},
      '{ROW_XFER, '{CMD_READ, 32'h0, 32'h0, 4'd2}, 1'b0, '0, 5'd0}
    };

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_table[r].kind == ROW_CAP) begin
        write_capacity(dir_table[r].cap);
      end else begin
        gap = ($urandom_range(3, 0) == 0) ? $urandom_range(15, 1) : 0;
        send_item(dir_table[r].item, gap, dir_table[r].typed, dir_table[r].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99, 0);
        item = '0;
        item.cmd        = CMD_UPDATE;
        item.slot_index = SLOT_W'($urandom_range(15, 0));
        item.seg_id     = ($urandom_range(99, 0) < 85) ? id_pool[$urandom_range(POOL_SIZE - 1, 0)]
                                                       : $urandom;
        read_limit = (written_upto > 16) ? 16 : written_upto;
        if (pick < 25 && read_limit > 0) begin
          item.cmd        = CMD_READ;
          item.slot_index = SLOT_W'($urandom_range(read_limit - 1, 0));
          item.score_key  = $urandom;
        end else if (pick < 33) begin
          item.score_key = $urandom_range(admit_thr, 0);
        end else if (pick < 36) begin
          // wide scores use pool ids so later updates can pull them back down
          item.seg_id    = id_pool[$urandom_range(POOL_SIZE - 1, 0)];
          item.score_key = $urandom;
        end else begin
          // keep just above the threshold so it climbs slowly
          headroom = 32'hFFFF_FFFF - admit_thr;
          if (headroom == 0)
            item.score_key = admit_thr;
          else
            item.score_key = admit_thr +
                             $urandom_range((headroom < SCORE_STEP) ? headroom : SCORE_STEP, 1);
        end
        gap = (p == N_PHASES - 1) ? 0 :
              ($urandom_range(4, 0) == 0) ? $urandom_range(15, 1) : 0;
        send_item(item, gap, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* keyed_top_k_score_set_unit.f */
hw/rtl/ktss_pkg.sv
hw/rtl/ktss_cell.sv
hw/rtl/ktss_chain.sv
hw/rtl/keyed_top_k_score_set_unit.sv
dv/testbench.sv
